// ===== hw/rtl/wqsv_pkg.sv =====
// Package with the shared constants, types and helper function of the velocity controller.
`timescale 1ns / 1ps
`default_nettype none
package wqsv_pkg;

  localparam int QueueDepth   = 32;
  localparam int FixedWidth   = 32;
  localparam int FractionBits = 16;
  localparam int QIdxW        = $clog2(QueueDepth);
  localparam int QCntW        = $clog2(QueueDepth + 1);
  localparam int ErrW         = FixedWidth + 1;
  localparam int ProdW        = 2 * FixedWidth;
  localparam int RootBits     = FixedWidth;
  localparam int RootCntW     = $clog2(RootBits);

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ODOM = 2'd0,
    OP_WAYPOINT = 2'd1,
    OP_SET_POSE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Waypoint command codes.
  typedef enum logic [1:0] {
    WP_POP = 2'd0,
    WP_CLEAR = 2'd1,
    WP_PUSH_FRONT = 2'd2,
    WP_PUSH_BACK = 2'd3
  } wp_mode_t;

  // Register indexes.
  localparam logic [2:0] REG_POS_GAIN  = 3'd0;
  localparam logic [2:0] REG_V_MAX     = 3'd1;
  localparam logic [2:0] REG_TURN_GAIN = 3'd2;
  localparam logic [2:0] REG_POS_TOL   = 3'd3;
  localparam logic [2:0] REG_ANG_TOL   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WP_READ,
    ST_WP_LOAD,
    ST_ODOM_ADD,
    ST_ODOM_MUL,
    ST_ROOT_X,
    ST_ROOT_Y,
    ST_FINISH,
    ST_POP_READ,
    ST_POP_LOAD,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic set_pose;
    logic wp_exec;
    logic rd_front;
    logic load_target;
    logic odom_add;
    logic mult;
    logic root_start;
    logic root_sel_y;
    logic finish;
    logic pop;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_load;
    logic root_done;
    logic reached;
  } stat_t;

  function automatic logic signed [FixedWidth-1:0] sat_add(
      input logic signed [FixedWidth-1:0] a, input logic signed [FixedWidth-1:0] b);
    logic signed [FixedWidth:0] s;
    s = {a[FixedWidth-1], a} + {b[FixedWidth-1], b};
    if (s[FixedWidth] != s[FixedWidth-1]) begin
      sat_add = s[FixedWidth] ? {1'b1, {(FixedWidth-1){1'b0}}}
                              : {1'b0, {(FixedWidth-1){1'b1}}};
    end else begin
      sat_add = s[FixedWidth-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wqsv_if.sv =====
// Valid and ready channel interfaces for the input, result and register write ports.
`timescale 1ns / 1ps
`default_nettype none
interface wqsv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_theta;
  logic [1:0]  waypoint_mode;
  modport source (output valid, operation, pos_x, pos_y, pos_theta, waypoint_mode,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_y, pos_theta, waypoint_mode,
                output ready);
endinterface

interface wqsv_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_pose_x;
  logic signed [31:0] out_pose_y;
  logic signed [31:0] out_pose_theta;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_turn;
  modport source (output valid, out_pose_x, out_pose_y, out_pose_theta, vel_x, vel_y,
                  vel_turn, input ready);
  modport sink (input valid, out_pose_x, out_pose_y, out_pose_theta, vel_x, vel_y,
                vel_turn, output ready);
endinterface

interface wqsv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wqsv_root.sv =====
// Bit-serial square root with an upper cap, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wqsv_root
  import wqsv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [ProdW-1:0]      radicand,
  input  wire logic [RootBits-1:0]   cap,
  output logic                       done,
  output logic [RootBits-1:0]        root
);

  logic                busy_r, busy_nxt;
  logic [RootCntW-1:0] bit_r, bit_nxt;
  logic [RootBits-1:0] root_r, root_nxt;
  logic [ProdW-1:0]    rad_r;
  logic [RootBits-1:0] cap_r;
  logic [RootBits-1:0] cand;
  logic [ProdW-1:0]    sq;

  // Try the next bit: keep it when within the cap and its square fits.
  always_comb begin
    cand     = root_r | (RootBits'(1) << bit_r);
    sq       = ProdW'(cand) * ProdW'(cand);
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = RootCntW'(RootBits - 1);
      root_nxt = '0;
    end else if (busy_r) begin
      if (cand <= cap_r && sq <= rad_r) root_nxt = cand;
      if (bit_r == '0) busy_nxt = 1'b0;
      else bit_nxt = bit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    bit_r  <= bit_nxt;
    root_r <= root_nxt;
    if (start) begin
      rad_r <= radicand;
      cap_r <= cap;
    end
  end

  assign done = busy_r && bit_r == '0;
  assign root = (cand <= cap_r && sq <= rad_r) ? cand : root_r;

endmodule
`default_nettype wire

// ===== hw/rtl/wqsv_datapath.sv =====
// Pose, target, waypoint memory, register file and velocity arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module wqsv_datapath
  import wqsv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  wqsv_in_if.sink          in_ch,
  wqsv_cfg_if.sink         cfg_ch,
  wqsv_out_if.source       out_ch,
  input  wire cmd_t        cmd,
  output stat_t            stat
);

  typedef logic signed [FixedWidth-1:0] fix_t;

  // Configuration registers.
  logic [31:0] pos_gain_r, v_max_r, turn_gain_r, pos_tol_r, ang_tol_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gain_r  <= 32'd9830;
      v_max_r     <= 32'd9830;
      turn_gain_r <= 32'd9175;
      pos_tol_r   <= 32'd1311;
      ang_tol_r   <= 32'd1144;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_POS_GAIN:  pos_gain_r  <= cfg_ch.data;
        REG_V_MAX:     v_max_r     <= cfg_ch.data;
        REG_TURN_GAIN: turn_gain_r <= cfg_ch.data;
        REG_POS_TOL:   pos_tol_r   <= cfg_ch.data;
        REG_ANG_TOL:   ang_tol_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Captured input item.
  wp_mode_t mode_r;
  fix_t     px_r, py_r, pt_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= wp_mode_t'(in_ch.waypoint_mode);
      px_r   <= in_ch.pos_x;
      py_r   <= in_ch.pos_y;
      pt_r   <= in_ch.pos_theta;
    end
  end

  // Waypoint memory, one word of x, y and theta per entry.
  logic [3*FixedWidth-1:0] mem [QueueDepth];
  logic [3*FixedWidth-1:0] rd_data_r;
  logic                    wr_en;
  logic [QIdxW-1:0]        wr_addr, rd_addr;
  logic [3*FixedWidth-1:0] wr_data;

  fix_t gx_r, gy_r, gt_r, tx_r, ty_r, tt_r;
  logic [QIdxW-1:0] head_r, head_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             need_load_r, need_load_nxt;
  logic             full;

  assign full = count_r == QCntW'(QueueDepth);

  // Queue pointer update for waypoint commands and pops.
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    need_load_nxt = need_load_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = {px_r, py_r, pt_r};
    if (cmd.wp_exec) begin
      need_load_nxt = 1'b0;
      unique case (mode_r)
        WP_POP: begin
          if (count_r != '0) begin
            head_nxt      = head_r + 1'b1;
            count_nxt     = count_r - 1'b1;
            need_load_nxt = count_r > QCntW'(1);
          end
        end
        WP_CLEAR: begin
          head_nxt      = '0;
          count_nxt     = QCntW'(1);
          wr_en         = 1'b1;
          wr_addr       = '0;
          wr_data       = {gx_r, gy_r, gt_r};
          need_load_nxt = 1'b1;
        end
        WP_PUSH_FRONT: begin
          if (!full) begin
            head_nxt      = head_r - 1'b1;
            count_nxt     = count_r + 1'b1;
            wr_en         = 1'b1;
            wr_addr       = head_r - 1'b1;
            need_load_nxt = 1'b1;
          end
        end
        WP_PUSH_BACK: begin
          if (!full) begin
            count_nxt     = count_r + 1'b1;
            wr_en         = 1'b1;
            wr_addr       = head_r + count_r[QIdxW-1:0];
            need_load_nxt = count_r == '0;
          end
        end
        default: ;
      endcase
    end else if (cmd.pop) begin
      need_load_nxt = 1'b0;
      if (count_r != '0) begin
        head_nxt      = head_r + 1'b1;
        count_nxt     = count_r - 1'b1;
        need_load_nxt = count_r > QCntW'(1);
      end
    end
  end

  assign rd_addr = head_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_front) rd_data_r <= mem[rd_addr];
  end

  // Errors, absolute values and products.
  logic signed [ErrW-1:0] ex, ey, et;
  logic [FixedWidth:0]    ax, ay, at;
  logic [ProdW-1:0]       px_prod_r, py_prod_r, pt_prod_r;
  logic signed [ErrW-1:0] ex_r, ey_r, et_r;

  assign ex = ErrW'(tx_r) - ErrW'(gx_r);
  assign ey = ErrW'(ty_r) - ErrW'(gy_r);
  assign et = ErrW'(tt_r) - ErrW'(gt_r);
  assign ax = ex_r[ErrW-1] ? (FixedWidth+1)'(-ex_r) : (FixedWidth+1)'(ex_r);
  assign ay = ey_r[ErrW-1] ? (FixedWidth+1)'(-ey_r) : (FixedWidth+1)'(ey_r);
  assign at = et_r[ErrW-1] ? (FixedWidth+1)'(-et_r) : (FixedWidth+1)'(et_r);

  // Pose, target and velocity registers.
  logic [RootBits-1:0] root_q;
  logic                root_done;
  logic [RootBits-1:0] lin_cap;
  logic [31:0]         vx_r, vy_r, vt_r;
  logic                reached_r;
  logic [ProdW-1:0]    turn_mag;
  logic [31:0]         turn_cap;

  assign lin_cap  = v_max_r[31] ? 32'h7FFF_FFFF : v_max_r;
  assign turn_cap = v_max_r >> 2;
  assign turn_mag = pt_prod_r >> FractionBits;

  wqsv_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (cmd.root_sel_y ? py_prod_r : px_prod_r),
    .cap      (lin_cap),
    .done     (root_done),
    .root     (root_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r <= '0; gy_r <= '0; gt_r <= '0;
      tx_r <= '0; ty_r <= '0; tt_r <= '0;
      head_r <= '0; count_r <= '0; need_load_r <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      need_load_r <= need_load_nxt;
      if (cmd.set_pose) begin
        gx_r <= px_r; gy_r <= py_r; gt_r <= pt_r;
      end
      if (cmd.odom_add) begin
        gx_r <= sat_add(gx_r, px_r);
        gy_r <= sat_add(gy_r, py_r);
        gt_r <= sat_add(gt_r, pt_r);
      end
      if (cmd.load_target) begin
        tx_r <= rd_data_r[3*FixedWidth-1:2*FixedWidth];
        ty_r <= rd_data_r[2*FixedWidth-1:FixedWidth];
        tt_r <= rd_data_r[FixedWidth-1:0];
      end
      if (cmd.out_load) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  // Products and velocity results.
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      px_prod_r <= ProdW'(ax) * ProdW'(pos_gain_r);
      py_prod_r <= ProdW'(ay) * ProdW'(pos_gain_r);
      pt_prod_r <= ProdW'(at) * ProdW'(turn_gain_r);
      reached_r <= ax < (FixedWidth+1)'(pos_tol_r) && ay < (FixedWidth+1)'(pos_tol_r)
                   && at < (FixedWidth+1)'(ang_tol_r);
    end
    if (root_done && !cmd.root_sel_y) vx_r <= ex_r[ErrW-1] ? -root_q : root_q;
    if (root_done && cmd.root_sel_y)  vy_r <= ey_r[ErrW-1] ? -root_q : root_q;
    if (cmd.finish) begin
      vt_r <= et_r[ErrW-1] ? -((turn_mag > ProdW'(turn_cap)) ? turn_cap : turn_mag[31:0])
                           : ((turn_mag > ProdW'(turn_cap)) ? turn_cap : turn_mag[31:0]);
    end
    if (cmd.out_load) begin
      out_ch.out_pose_x     <= gx_r;
      out_ch.out_pose_y     <= gy_r;
      out_ch.out_pose_theta <= gt_r;
      out_ch.vel_x          <= vx_r;
      out_ch.vel_y          <= vy_r;
      out_ch.vel_turn       <= vt_r;
    end
  end

  // Error registers, taken in the cycle after the pose update.
  logic err_take_r;
  always_ff @(posedge clk) begin
    if (!rst_n) err_take_r <= 1'b0;
    else err_take_r <= cmd.odom_add;
  end
  always_ff @(posedge clk) begin
    if (err_take_r) begin
      ex_r <= ex; ey_r <= ey; et_r <= et;
    end
  end

  assign stat.need_load = need_load_r;
  assign stat.root_done = root_done;
  assign stat.reached   = reached_r;

endmodule
`default_nettype wire

// ===== hw/rtl/wqsv_ctrl.sv =====
// Sequencing state machine of the velocity controller.
`timescale 1ns / 1ps
`default_nettype none
module wqsv_ctrl
  import wqsv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic [1:0] in_op,
  output logic       in_ready,
  input  wire logic  out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   mul_wait_r;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mul_wait_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mul_wait_r <= state_r == ST_ODOM_ADD;
    end
  end

  // The result register can take a new result once the waiting one leaves.
  assign out_free = !out_valid || out_ready;
  assign in_ready = state_r == ST_IDLE;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (op_t'(in_op))
            OP_ODOM:     state_nxt = ST_ODOM_ADD;
            OP_WAYPOINT: state_nxt = ST_WP_READ;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WP_READ:  state_nxt = ST_WP_LOAD;
      ST_WP_LOAD:  state_nxt = ST_IDLE;
      ST_ODOM_ADD: state_nxt = ST_ODOM_MUL;
      ST_ODOM_MUL: if (!mul_wait_r) state_nxt = ST_ROOT_X;
      ST_ROOT_X:   if (stat.root_done) state_nxt = ST_ROOT_Y;
      ST_ROOT_Y:   if (stat.root_done) state_nxt = ST_FINISH;
      ST_FINISH:   state_nxt = stat.reached ? ST_POP_READ : ST_OUT;
      ST_POP_READ: state_nxt = ST_POP_LOAD;
      ST_POP_LOAD: state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
        end
      end
      ST_WP_READ:  cmd.wp_exec = 1'b1;
      ST_WP_LOAD:  cmd.rd_front = 1'b1;
      ST_ODOM_ADD: cmd.odom_add = 1'b1;
      ST_ODOM_MUL: begin
        cmd.mult       = mul_wait_r ? 1'b0 : 1'b1;
        cmd.root_start = 1'b0;
      end
      ST_ROOT_X:   cmd.root_sel_y = 1'b0;
      ST_ROOT_Y:   cmd.root_sel_y = 1'b1;
      ST_FINISH:   cmd.finish = 1'b1;
      ST_POP_READ: cmd.pop = 1'b1;
      ST_POP_LOAD: cmd.rd_front = 1'b1;
      ST_OUT:      cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/waypoint_queue_sqrt_velocity_controller.sv =====
// Top level of the waypoint queue square-root velocity controller.
// Use:
//   in_*  : item transfer (operation, pose fields, waypoint mode) on valid and ready.
//   out_* : one result transfer per odometry item: new pose and three velocities.
//   cfg_* : register writes by index, always ready; write only while idle.
// Flow: one item at a time. A set-pose item frees the input on the next cycle and the
// pose is written at that cycle's end. A waypoint command frees the input after the
// queue update and the memory read; the target is loaded at the end of the cycle in
// which the input frees. An odometry item passes the pose add, the products, the
// bit-serial square roots for x and then for y, the turn rate, a pop and queue read when
// the waypoint is reached, and the result load; its result shows as the input frees.
// The waypoint queue lives in a 32-entry memory read through one registered port.
// Reset: synchronous and active low; registers return to their defaults, pose,
// target and queue count clear. The memory itself is not cleared.
// Stall: a waiting result does not block the input; the next odometry item is worked
// out and then held until the waiting result has been transferred.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_queue_sqrt_velocity_controller
  import wqsv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  wqsv_in_if.sink   in_ch,
  wqsv_out_if.source out_ch,
  wqsv_cfg_if.sink  cfg_ch
);

  cmd_t  cmd, cmd_dp;
  stat_t stat;

  wqsv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Set-pose executes straight from the capture cycle's follower.
  logic setp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setp_r <= 1'b0;
    end else begin
      setp_r <= cmd.capture && in_ch.operation == OP_SET_POSE;
    end
  end

  // Root start pulses, and target load after a memory read when a load is needed.
  logic rd_r, mul_r, rx_done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; mul_r <= 1'b0; rx_done_r <= 1'b0;
    end else begin
      rd_r      <= cmd.rd_front && stat.need_load;
      mul_r     <= cmd.mult;
      rx_done_r <= stat.root_done && !cmd.root_sel_y;
    end
  end

  always_comb begin
    cmd_dp             = cmd;
    cmd_dp.set_pose    = setp_r;
    cmd_dp.load_target = rd_r;
    cmd_dp.root_start  = mul_r || rx_done_r;
    cmd_dp.root_sel_y  = cmd.root_sel_y || rx_done_r;
  end

  wqsv_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch),
    .cmd    (cmd_dp),
    .stat   (stat)
  );

endmodule
`default_nettype wire

// ===== sim/waypoint_queue_sqrt_velocity_controller_tb.sv =====
// Self-checking testbench for the waypoint queue square-root velocity controller.
`timescale 1ns / 1ps
module waypoint_queue_sqrt_velocity_controller_tb;
  import wqsv_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 100;
  localparam logic [2:0] RegUnmapped = 3'd7;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pth;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vt;
  } motion_t;

  typedef struct {
    op_t              op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] th;
    wp_mode_t         mode;
    bit               typed;
    motion_t          res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wqsv_in_if  in_ch ();
  wqsv_out_if out_ch ();
  wqsv_cfg_if cfg_ch ();

  waypoint_queue_sqrt_velocity_controller dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the controller.
  logic [31:0]        m_pos_gain, m_vmax, m_turn_gain, m_pos_tol, m_ang_tol;
  logic signed [31:0] m_pose [3];
  logic signed [31:0] m_target [3];
  logic signed [31:0] m_queue [QueueDepth][3];
  int unsigned        m_head, m_count;

  motion_t motion_q[$];
  int      errors = 0;
  int      idle_pct = 32;
  bit      hold_off = 1'b0;
  bit      fed = 1'b0;
  int      quiet = 0;

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] linear_speed(input longint e);
    logic [63:0] p, cap, r, c, m;
    if (e == 0) return 0;
    m = (e < 0) ? -e : e;
    p = m * m_pos_gain;
    cap = (m_vmax < 32'h7fffffff) ? m_vmax : 32'h7fffffff;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c <= cap && c * c <= p) r = c;
    end
    return (e < 0) ? -r[31:0] : r[31:0];
  endfunction

  function automatic logic signed [31:0] turn_speed(input longint e);
    logic [63:0] m;
    m = (e < 0) ? -e : e;
    m = (m * m_turn_gain) >> FractionBits;
    if (m > (m_vmax >> 2)) m = m_vmax >> 2;
    return (e < 0) ? -m[31:0] : m[31:0];
  endfunction

  task automatic load_front();
    for (int i = 0; i < 3; i++) m_target[i] = m_queue[m_head][i];
  endtask

  task automatic drop_head();
    if (m_count == 0) return;
    m_head = (m_head + 1) % QueueDepth;
    m_count--;
    if (m_count > 0) load_front();
  endtask

  // Applies one accepted item and queues the motion result it causes.
  task automatic advance_controller(input op_t op, input logic signed [31:0] x,
                                    input logic signed [31:0] y,
                                    input logic signed [31:0] th, input wp_mode_t mode);
    logic signed [31:0] p [3];
    longint e [3];
    motion_t r;
    int unsigned slot;
    p[0] = x; p[1] = y; p[2] = th;
    case (op)
      OP_WAYPOINT: begin
        case (mode)
          WP_POP: drop_head();
          WP_CLEAR: begin
            m_head = 0; m_count = 1;
            for (int i = 0; i < 3; i++) m_queue[0][i] = m_pose[i];
            load_front();
          end
          WP_PUSH_FRONT: if (m_count < QueueDepth) begin
            m_head = (m_head + QueueDepth - 1) % QueueDepth;
            for (int i = 0; i < 3; i++) m_queue[m_head][i] = p[i];
            m_count++;
            load_front();
          end
          default: if (m_count < QueueDepth) begin
            slot = (m_head + m_count) % QueueDepth;
            for (int i = 0; i < 3; i++) m_queue[slot][i] = p[i];
            m_count++;
            if (m_count == 1) load_front();
          end
        endcase
      end
      OP_SET_POSE: for (int i = 0; i < 3; i++) m_pose[i] = p[i];
      OP_ODOM: begin
        for (int i = 0; i < 3; i++) begin
          m_pose[i] = sadd(m_pose[i], p[i]);
          e[i] = longint'(m_target[i]) - longint'(m_pose[i]);
        end
        r.px = m_pose[0]; r.py = m_pose[1]; r.pth = m_pose[2];
        r.vx = linear_speed(e[0]);
        r.vy = linear_speed(e[1]);
        r.vt = turn_speed(e[2]);
        if ((e[0] < 0 ? -e[0] : e[0]) < m_pos_tol && (e[1] < 0 ? -e[1] : e[1]) < m_pos_tol
            && (e[2] < 0 ? -e[2] : e[2]) < m_ang_tol) drop_head();
        motion_q.insert(motion_q.size(), r);
      end
      default: ;
    endcase
  endtask

  // Sender: drives one item at the falling edge, holds it until the transfer.
  task automatic send_item(input op_t op, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] th,
                           input wp_mode_t mode);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.pos_x <= x; in_ch.pos_y <= y; in_ch.pos_theta <= th;
    in_ch.waypoint_mode <= mode;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_controller(op, x, y, th, mode);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (motion_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_POS_GAIN:  m_pos_gain = val;
      REG_V_MAX:     m_vmax = val;
      REG_TURN_GAIN: m_turn_gain = val;
      REG_POS_TOL:   m_pos_tol = val;
      REG_ANG_TOL:   m_ang_tol = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: random ready with optional hold-off; checks each transfer.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (motion_q.size() == 0) begin
        $display("%0t: unexpected result pose_x %h", $time, out_ch.out_pose_x);
        errors++;
      end else begin
        motion_t w, g;
        w = motion_q[0];
        motion_q.delete(0);
        g = {out_ch.out_pose_x, out_ch.out_pose_y, out_ch.out_pose_theta,
             out_ch.vel_x, out_ch.vel_y, out_ch.vel_turn};
        if (g.px !== w.px) begin
          $display("%0t: pose_x exp %h got %h", $time, w.px, g.px); errors++;
        end
        if (g.py !== w.py) begin
          $display("%0t: pose_y exp %h got %h", $time, w.py, g.py); errors++;
        end
        if (g.pth !== w.pth) begin
          $display("%0t: theta exp %h got %h", $time, w.pth, g.pth); errors++;
        end
        if (g.vx !== w.vx) begin
          $display("%0t: vel_x exp %h got %h", $time, w.vx, g.vx); errors++;
        end
        if (g.vy !== w.vy) begin
          $display("%0t: vel_y exp %h got %h", $time, w.vy, g.vy); errors++;
        end
        if (g.vt !== w.vt) begin
          $display("%0t: vel_turn exp %h got %h", $time, w.vt, g.vt); errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on the input or the result channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_fix();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(8000)) - 4000;
      default: return $signed($urandom_range(400000)) - 200000;
    endcase
  endfunction

  row_t dir_rows [$];

  task automatic add_row(input op_t op, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] th, input wp_mode_t mode);
    row_t r;
    r.op = op; r.x = x; r.y = y; r.th = th; r.mode = mode; r.typed = 1'b0; r.res = '0;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    int n_out;
    row_t r;
    op_t op;
    in_ch.valid = 1'b0; in_ch.operation = OP_NONE; in_ch.pos_x = 0; in_ch.pos_y = 0;
    in_ch.pos_theta = 0; in_ch.waypoint_mode = WP_POP;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_POS_GAIN; cfg_ch.data = 0;
    m_pos_gain = 9830; m_vmax = 9830; m_turn_gain = 9175; m_pos_tol = 1311; m_ang_tol = 1144;
    for (int i = 0; i < 3; i++) begin m_pose[i] = 0; m_target[i] = 0; end
    m_head = 0; m_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. The first odometry after reset sits on the target: all zero.
    add_row(OP_ODOM, 0, 0, 0, WP_POP);
    dir_rows[0].typed = 1'b1;
    add_row(OP_WAYPOINT, 0, 0, 0, WP_POP);                          // pop of empty queue
    add_row(OP_WAYPOINT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, WP_PUSH_BACK);
    add_row(OP_ODOM, 32'h7fffffff, 32'h7fffffff, 32'h80000000, WP_POP); // limit values; x saturates next
    add_row(OP_ODOM, 32'h7fffffff, 32'h80000000, 32'h7fffffff, WP_POP);
    add_row(OP_SET_POSE, 32'h80000000, 32'h7fffffff, 32'h80000000, WP_POP);
    add_row(OP_ODOM, 32'h80000000, 32'h7fffffff, 32'h80000000, WP_POP);
    add_row(OP_WAYPOINT, 32'h00010000, 32'hffff0000, 32'h00008000, WP_PUSH_FRONT);
    add_row(OP_WAYPOINT, 0, 0, 0, WP_CLEAR);                        // target becomes pose
    add_row(OP_ODOM, 0, 0, 0, WP_POP);                              // reached, queue empties
    add_row(OP_ODOM, 100, -100, 50, WP_POP);                        // reached on empty queue
    add_row(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, WP_PUSH_BACK); // ignored
    add_row(OP_SET_POSE, 0, 0, 0, WP_POP);
    add_row(OP_WAYPOINT, 32'h00050000, 32'hfffb0000, 32'h00010000, WP_PUSH_BACK);
    add_row(OP_ODOM, 32'h00010000, 32'h00010000, 0, WP_POP);
    add_row(OP_ODOM, 32'h00040000, 32'hfffa0000, 32'h00010000, WP_POP);
    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      send_item(r.op, r.x, r.y, r.th, r.mode);
      if (r.typed) motion_q[motion_q.size()-1] = r.res;
    end
    wait_drained();

    // Register settings, the extremes among them, with random phases.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_POS_GAIN, 32'hffffffff); write_reg(REG_V_MAX, 32'hffffffff);
                 write_reg(REG_TURN_GAIN, 32'hffffffff); write_reg(REG_POS_TOL, 32'hffffffff);
                 write_reg(REG_ANG_TOL, 32'hffffffff); end
        1: begin write_reg(REG_POS_GAIN, 0); write_reg(REG_V_MAX, 0);
                 write_reg(REG_TURN_GAIN, 0); write_reg(REG_POS_TOL, 0);
                 write_reg(REG_ANG_TOL, 0); end
        2: write_reg(RegUnmapped, 32'h12345678);                    // unmapped index
        default: begin write_reg(REG_POS_GAIN, $urandom_range(200000));
                 write_reg(REG_V_MAX, $urandom); write_reg(REG_TURN_GAIN, $urandom_range(300000));
                 write_reg(REG_POS_TOL, $urandom_range(1 << 20));
                 write_reg(REG_ANG_TOL, $urandom_range(1 << 20)); end
      endcase
      if (phase == 4) idle_pct = 0;                                 // stretch with no idling
      else idle_pct = 32;
      if (phase == 3) begin
        // Receiver holds off while the sender keeps offering items.
        fork
          begin hold_off = 1'b1; repeat (400) @(negedge clk); hold_off = 1'b0; end
        join_none
      end
      for (int k = 0; k < 100; k++) begin
        n_out = $urandom_range(99);
        if (n_out < 55) op = OP_ODOM;
        else if (n_out < 85) op = OP_WAYPOINT;
        else if (n_out < 95) op = OP_SET_POSE;
        else op = OP_NONE;
        send_item(op, rand_fix(), rand_fix(), rand_fix(), wp_mode_t'($urandom_range(3)));
        if (k == 50) wait_drained();                                // sender pause
      end
      wait_drained();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
